// File: rtl/wsd_pkg.sv
// Package for the WebSocket client-frame deframer.
// Holds the parser phase type, the result word layout and the protocol codes.
// No dependencies; every other file of the block imports it.
package wsd_pkg;

  // Width of the payload length register; the extended length wraps at this width
  localparam int unsigned LEN_W = 64;

  // Queue depth between the parser and the output stage
  localparam int unsigned Q_DEPTH = 2;
  localparam int unsigned Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Header fields
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [3:0] EXT16_BYTES = 4'd2;
  localparam logic [3:0] EXT64_BYTES = 4'd8;

  // Message types
  localparam logic [1:0] MT_TEXT   = 2'd0;
  localparam logic [1:0] MT_BINARY = 2'd1;
  localparam logic [1:0] MT_CLOSE  = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_FIN_CLEAR  = 2'd1;
  localparam logic [1:0] ST_MASK_CLEAR = 2'd2;
  localparam logic [1:0] ST_BAD_OPCODE = 2'd3;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef struct packed {
    logic       empty_message;
    logic [1:0] status;
    logic [1:0] msg_type;
    logic       end_of_message;
    logic [7:0] payload_byte;
  } result_t;

endpackage

// File: rtl/websocket_frame_deframer.sv
// Client-to-server WebSocket deframer: takes one frame byte per cycle on the
// slave stream and returns unmasked payload bytes on the master stream, tagged
// with message type, status and a last flag. A byte is taken every cycle while
// the two-entry result queue has room, so the sustained rate is one byte per
// cycle while the master stream does not stall; a result passes through the
// queue and then the output register. Header, length and mask bytes give no
// word; a zero-length frame gives one empty word, and a bad header gives one
// error word after which all bytes are swallowed until reset. Depends on
// wsd_pkg, wsd_parser, wsd_queue and wsd_out.
module websocket_frame_deframer (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // data_byte[7:0]
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // payload_byte[7:0]
  output logic [4:0] m_axis_tuser,   // msg_type[1:0], status[3:2], empty_message[4]
  output logic       m_axis_tlast    // end_of_message
);
  import wsd_pkg::*;

  logic    res_valid;
  result_t res;
  logic    q_full, q_valid, q_pop;
  result_t q_head;

  assign s_axis_tready = !q_full;

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  wsd_out u_out (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// File: rtl/wsd_parser.sv
// Front end of the deframer: walks the frame header, length, mask and payload
// one byte per cycle while in_ready is high and no bad header has halted it,
// and produces at most one result word per byte. Depends on wsd_pkg.
module wsd_parser (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic             in_ready,
  input  logic [7:0]       in_data,
  output logic             res_valid,
  output wsd_pkg::result_t res
);
  import wsd_pkg::*;

  phase_t            phase, phase_next;
  logic [1:0]        frame_type, frame_type_next;
  logic [1:0]        pend_err, pend_err_next;
  logic [3:0]        ext_left, ext_left_next;
  logic [LEN_W-1:0]  payload_left, payload_left_next;
  logic [31:0]       mask_word, mask_word_next;
  logic [1:0]        byte_index, byte_index_next;
  logic              halted, halted_next;

  logic              step;
  logic [6:0]        len7;
  logic [1:0]        hdr1_status;
  logic [7:0]        mask_byte;
  logic [LEN_W-1:0]  payload_dec;
  logic              last_byte;
  logic [1:0]        op_type;
  logic [1:0]        op_err;

  assign step        = in_valid && in_ready && !halted;
  assign len7        = in_data[6:0];
  assign payload_dec = payload_left - LEN_W'(1);
  assign last_byte   = (payload_dec == '0);
  // Key byte 0 sits in the top byte of the mask word
  assign mask_byte   = mask_word[{~byte_index, 3'b111} -: 8];

  // FIN clear beats MASK clear
  always_comb begin
    hdr1_status = pend_err;
    if (pend_err != ST_FIN_CLEAR && !in_data[7]) begin
      hdr1_status = ST_MASK_CLEAR;
    end
  end

  always_comb begin
    op_type = MT_TEXT;
    op_err  = ST_OK;
    unique case (in_data[3:0])
      OP_TEXT:   op_type = MT_TEXT;
      OP_BINARY: op_type = MT_BINARY;
      OP_CLOSE:  op_type = MT_CLOSE;
      default:   op_err  = ST_BAD_OPCODE;
    endcase
    if (!in_data[7]) begin
      op_err = ST_FIN_CLEAR;
    end
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    if (step) begin
      unique case (phase)
        PH_HDR0: phase_next = PH_HDR1;
        PH_HDR1: begin
          if (hdr1_status != ST_OK) begin
            phase_next = PH_HDR0;
          end else if (len7 == LEN7_EXT16 || len7 == LEN7_EXT64) begin
            phase_next = PH_EXTLEN;
          end else begin
            phase_next = PH_MASK;
          end
        end
        PH_EXTLEN: begin
          if (ext_left == 4'd1) begin
            phase_next = PH_MASK;
          end
        end
        PH_MASK: begin
          if (byte_index == 2'd3) begin
            phase_next = (payload_left == '0) ? PH_HDR0 : PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (last_byte) begin
            phase_next = PH_HDR0;
          end
        end
        default: phase_next = PH_HDR0;
      endcase
    end
  end

  // Datapath registers
  always_comb begin
    frame_type_next   = frame_type;
    pend_err_next     = pend_err;
    ext_left_next     = ext_left;
    payload_left_next = payload_left;
    mask_word_next    = mask_word;
    byte_index_next   = byte_index;
    halted_next       = halted;
    if (step) begin
      unique case (phase)
        PH_HDR0: begin
          frame_type_next = op_type;
          pend_err_next   = op_err;
        end
        PH_HDR1: begin
          if (hdr1_status != ST_OK) begin
            halted_next = 1'b1;
          end else begin
            byte_index_next = 2'd0;
            mask_word_next  = '0;
            if (len7 == LEN7_EXT16) begin
              ext_left_next     = EXT16_BYTES;
              payload_left_next = '0;
            end else if (len7 == LEN7_EXT64) begin
              ext_left_next     = EXT64_BYTES;
              payload_left_next = '0;
            end else begin
              ext_left_next     = 4'd0;
              payload_left_next = LEN_W'(len7);
            end
          end
        end
        PH_EXTLEN: begin
          payload_left_next = {payload_left[LEN_W-9:0], in_data};
          ext_left_next     = ext_left - 4'd1;
        end
        PH_MASK: begin
          mask_word_next  = {mask_word[23:0], in_data};
          byte_index_next = byte_index + 2'd1;
        end
        PH_PAYLOAD: begin
          payload_left_next = payload_dec;
          byte_index_next   = byte_index + 2'd1;
        end
        default: ;
      endcase
    end
  end

  // Result word
  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    if (step) begin
      unique case (phase)
        PH_HDR1: begin
          if (hdr1_status != ST_OK) begin
            res_valid          = 1'b1;
            res.status         = hdr1_status;
            res.end_of_message = 1'b1;
          end
        end
        PH_MASK: begin
          if (byte_index == 2'd3 && payload_left == '0) begin
            res_valid          = 1'b1;
            res.msg_type       = frame_type;
            res.end_of_message = 1'b1;
            res.empty_message  = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          res_valid          = 1'b1;
          res.payload_byte   = in_data ^ mask_byte;
          res.msg_type       = frame_type;
          res.end_of_message = last_byte;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HDR0;
      frame_type   <= 2'd0;
      pend_err     <= ST_OK;
      ext_left     <= 4'd0;
      payload_left <= '0;
      mask_word    <= '0;
      byte_index   <= 2'd0;
      halted       <= 1'b0;
    end else begin
      phase        <= phase_next;
      frame_type   <= frame_type_next;
      pend_err     <= pend_err_next;
      ext_left     <= ext_left_next;
      payload_left <= payload_left_next;
      mask_word    <= mask_word_next;
      byte_index   <= byte_index_next;
      halted       <= halted_next;
    end
  end

endmodule

// File: rtl/wsd_queue.sv
// Short result queue between the parser and the output stage.
// Depends on wsd_pkg for the result word and the depth.
module wsd_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  wsd_pkg::result_t push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output wsd_pkg::result_t head
);
  import wsd_pkg::*;

  result_t              mem [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0]   count;
  logic                 do_push, do_pop;

  assign full      = (count == Q_CNT_W'(Q_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr + Q_PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr + Q_PTR_W'(1);
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// File: rtl/wsd_out.sv
// Back end of the deframer: output register that drives the master stream.
// Depends on wsd_pkg for the result word.
module wsd_out (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  input  wsd_pkg::result_t q_head,
  output logic             q_pop,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,  // payload_byte[7:0]
  output logic [4:0]       m_axis_tuser,  // msg_type[1:0], status[3:2], empty_message[4]
  output logic             m_axis_tlast
);
  import wsd_pkg::*;

  result_t hold;
  logic    load;

  // Reload from the queue head, when it holds a word, whenever the register is empty or its word is taken
  assign load  = q_valid && (!m_axis_tvalid || m_axis_tready);
  assign q_pop = load;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= q_head;
    end
  end

  assign m_axis_tdata = hold.payload_byte;
  assign m_axis_tuser = {hold.empty_message, hold.status, hold.msg_type};
  assign m_axis_tlast = hold.end_of_message;

endmodule
